>>> sv/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared types and constants for the LRC frame receiver.
// ----------------------------------------------------------------------------
package lrc_pkg;

    localparam logic [7:0] HDR_TO_HOST    = 8'hAA;
    localparam logic [7:0] HDR_TO_DEV     = 8'h55;
    localparam logic [7:0] FRAME_LEN_CODE = 8'h0D;

    localparam int STORE_DEPTH = 12;
    localparam int DATA_BYTES  = 9;
    localparam int IDX_W       = 4;

    // Frame positions
    localparam int POS_HDR = 0;
    localparam int POS_CMD = 2;
    localparam int POS_DAT = 3;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HEAD = 2'd1,
        PH_LEN  = 2'd2,
        PH_BODY = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_BAD_LRC = 2'd1,
        ST_BAD_LEN = 2'd2
    } status_t;

    typedef struct packed {
        status_t                          status;
        logic                             from_afe;
        logic [7:0]                       command;
        logic [DATA_BYTES-1:0][7:0]       data;
    } result_t;

endpackage

>>> sv/lrc_frame_receiver.sv
// ----------------------------------------------------------------------------
// lrc_frame_receiver
// Deframes fixed 13-byte frames with LRC check from a received byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / rx_byte) takes one received word per
//   handshake. A frame is header (0xAA or 0x55), length (0x0D), command,
//   nine data bytes and an LRC byte; the LRC is the two's complement of the
//   8-bit sum of the first twelve bytes. Words outside a frame that are not
//   a header are dropped without a result.
//   Output channel (out_valid / out_ready / status, from_afe, command,
//   data_0..data_8) carries one result per completed frame (status good or
//   checksum mismatch) and one per bad length byte (status bad length, with
//   command and data zeroed); a bad length byte returns the parser to the hunt.
//   Each result is registered from the word that completes it.
//   Throughput: one word per cycle while in_ready is high. The parser,
//   running sum and frame store update in the same cycle a word is accepted.
//   Stall: results sit in an output register backed by a one-entry skid
//   register, so words keep flowing while one result waits; in_ready drops
//   only when both are full.
//   Reset: rst_n (async, active low) returns the parser to the hunt and
//   empties both output slots; the frame store is not cleared.
// ----------------------------------------------------------------------------
module lrc_frame_receiver (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic       from_afe,
    output logic [7:0] command,
    output logic [7:0] data_0,
    output logic [7:0] data_1,
    output logic [7:0] data_2,
    output logic [7:0] data_3,
    output logic [7:0] data_4,
    output logic [7:0] data_5,
    output logic [7:0] data_6,
    output logic [7:0] data_7,
    output logic [7:0] data_8
);
    import lrc_pkg::*;

    // Parser state
    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       store_reg [STORE_DEPTH];

    // Output register and skid slot
    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;

    logic       accept, pop;
    logic       emit;
    logic       put;        // store the word and advance index and sum
    logic       restart;    // header seen: start a fresh frame
    result_t    res;
    logic [IDX_W-1:0] put_idx;
    logic [7:0]       put_sum;
    logic [7:0]       expect_lrc;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign pop      = out_valid_reg && out_ready;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == HDR_TO_HOST || rx_byte == HDR_TO_DEV)
                        phase_next = PH_HEAD;
                end
                PH_HEAD: phase_next = (rx_byte == FRAME_LEN_CODE) ? PH_LEN : PH_HUNT;
                PH_LEN:  phase_next = PH_BODY;
                PH_BODY:
                begin
                    if (idx_reg >= IDX_W'(STORE_DEPTH))
                        phase_next = PH_HUNT;
                end
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    // Datapath control and result
    always_comb
    begin
        emit    = 1'b0;
        put     = 1'b0;
        restart = 1'b0;
        res     = '0;
        res.from_afe = (store_reg[POS_HDR] == HDR_TO_HOST);
        expect_lrc   = 8'(8'd0 - sum_reg);
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == HDR_TO_HOST || rx_byte == HDR_TO_DEV)
                begin
                    restart = 1'b1;
                    put     = 1'b1;
                end
            end
            PH_HEAD:
            begin
                if (rx_byte == FRAME_LEN_CODE)
                    put = 1'b1;
                else
                begin
                    emit       = 1'b1;
                    res.status = ST_BAD_LEN;
                end
            end
            PH_LEN: put = 1'b1;
            PH_BODY:
            begin
                if (idx_reg < IDX_W'(STORE_DEPTH))
                    put = 1'b1;
                else
                begin
                    emit        = 1'b1;
                    res.status  = (expect_lrc == rx_byte) ? ST_GOOD : ST_BAD_LRC;
                    res.command = store_reg[POS_CMD];
                    for (int k = 0; k < DATA_BYTES; k++)
                        res.data[k] = store_reg[POS_DAT + k];
                end
            end
            default: ;
        endcase

        // A header restarts index and sum before the put
        put_idx  = restart ? '0 : idx_reg;
        put_sum  = restart ? 8'd0 : sum_reg;
        idx_next = idx_reg;
        sum_next = sum_reg;
        if (accept && put)
        begin
            idx_next = put_idx + 1'b1;
            sum_next = put_sum + rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            idx_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
        end
    end

    // Frame store: one write port, entries read at fixed positions
    always_ff @(posedge clk)
    begin
        if (accept && put && put_idx < IDX_W'(STORE_DEPTH))
            store_reg[put_idx] <= rx_byte;
    end

    // Output slot and skid slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept && emit)
        begin
            if (!out_valid_reg || pop)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (accept && emit)
        begin
            if (!out_valid_reg || pop)
                out_reg <= res;
            else
                skid_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_reg.status;
    assign from_afe  = out_reg.from_afe;
    assign command   = out_reg.command;
    assign data_0    = out_reg.data[0];
    assign data_1    = out_reg.data[1];
    assign data_2    = out_reg.data[2];
    assign data_3    = out_reg.data[3];
    assign data_4    = out_reg.data[4];
    assign data_5    = out_reg.data[5];
    assign data_6    = out_reg.data[6];
    assign data_7    = out_reg.data[7];
    assign data_8    = out_reg.data[8];

endmodule

>>> sv/lrc_checker.sv
// ----------------------------------------------------------------------------
// lrc_checker
// Port-level checks for the LRC frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module lrc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic       from_afe,
    input logic [7:0] command,
    input logic [7:0] data_0,
    input logic [7:0] data_1,
    input logic [7:0] data_2,
    input logic [7:0] data_3,
    input logic [7:0] data_4,
    input logic [7:0] data_5,
    input logic [7:0] data_6,
    input logic [7:0] data_7,
    input logic [7:0] data_8
);
    import lrc_pkg::*;

    // Backpressure only when a result is already waiting
    a_ready_low_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("in_ready low with no result held");

    // Held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(command)
            && $stable(from_afe) && $stable(data_0) && $stable(data_1)
            && $stable(data_2) && $stable(data_3) && $stable(data_4)
            && $stable(data_5) && $stable(data_6) && $stable(data_7)
            && $stable(data_8))
        else $error("stalled result changed");

    // Only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_GOOD || status == ST_BAD_LRC || status == ST_BAD_LEN))
        else $error("undefined status code");

    // Bad length results carry no frame body
    a_bad_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_BAD_LEN |-> command == 8'd0 && data_0 == 8'd0
            && data_1 == 8'd0 && data_2 == 8'd0 && data_3 == 8'd0
            && data_4 == 8'd0 && data_5 == 8'd0 && data_6 == 8'd0
            && data_7 == 8'd0 && data_8 == 8'd0)
        else $error("bad length result carries body bytes");

    // A result needs a word accepted before it
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result appeared without an accepted word");

endmodule

bind lrc_frame_receiver lrc_checker u_lrc_checker (.*);
